### rtl/cpu_trace_rule_checker_assert.svh
// Assertion macros for the checker RTL.
`ifndef CPU_TRACE_RULE_CHECKER_ASSERT_SVH
`define CPU_TRACE_RULE_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define CTRC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CTRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ctrc_pkg.sv
`timescale 1ns / 1ps

package ctrc_pkg;

    localparam int unsigned DEF_MAX_TARGETS = 64;

    localparam logic [15:0] ROM_LOW_RST  = 16'hC000;
    localparam logic [15:0] ROM_HIGH_RST = 16'hFFFF;
    localparam logic [15:0] SIO_VEC_RST  = 16'hE459;

    localparam logic [7:0] OP_LDA_ZP = 8'hA5;
    localparam logic [7:0] OP_LDX_ZP = 8'hA6;
    localparam logic [7:0] OP_LDY_ZP = 8'hA4;
    localparam logic [7:0] OP_JSR    = 8'h20;
    localparam logic [7:0] OP_JMP    = 8'h4C;
    localparam logic [7:0] OP_RTI    = 8'h40;

    localparam logic [7:0] NMI_WINDOW = 8'd8;

    localparam int EN_NMI  = 0;
    localparam int EN_KERN = 1;
    localparam int EN_IRQR = 2;
    localparam int EN_ZERO = 3;
    localparam int EN_SIO  = 4;
    localparam int EN_WRAP = 5;
    localparam int EN_DMA  = 6;

    localparam int FK_ZERO = 0;
    localparam int FK_KERN = 1;
    localparam int FK_SIO  = 2;
    localparam int FK_REGS = 3;
    localparam int FK_NMI  = 4;
    localparam int FK_WRAP = 5;
    localparam int FK_DMA  = 6;

    typedef enum logic [2:0] {
        CMD_INSN,
        CMD_IRQ,
        CMD_NMI,
        CMD_RESET,
        CMD_ADD,
        CMD_REMOVE,
        CMD_CLEAR,
        CMD_DMA
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_ENABLES,
        CFG_ROM_LOW,
        CFG_ROM_HIGH,
        CFG_SIO_VEC
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WAIT,
        ST_EMIT
    } top_state_t;

    typedef enum logic {
        TS_IDLE,
        TS_SCAN
    } ts_state_t;

    typedef enum logic [1:0] {
        TS_LOOKUP,
        TS_ADD,
        TS_REMOVE,
        TS_CLEAR
    } ts_op_t;

    typedef struct packed {
        logic        start;
        ts_op_t      op;
        logic [15:0] addr;
    } ts_req_t;

    typedef struct packed {
        logic done;
        logic found;
        logic full;
    } ts_rsp_t;

    function automatic logic op_abs_x(input logic [7:0] op);
        logic r;
        unique case (op)
            8'h1D, 8'h1E, 8'h3D, 8'h3E, 8'h5D, 8'h5E, 8'h7D, 8'h7E,
            8'h9D, 8'hBC, 8'hBD, 8'hDD, 8'hDE, 8'hFD, 8'hFE: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic op_y_indexed(input logic [7:0] op);
        logic r;
        unique case (op)
            8'h19, 8'h39, 8'h59, 8'h79, 8'h99, 8'hB9, 8'hBE, 8'hD9, 8'hF9,
            8'h11, 8'h31, 8'h51, 8'h71, 8'h91, 8'hB1, 8'hD1, 8'hF1: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/ctrc_target_set.sv
`timescale 1ns / 1ps

module ctrc_target_set
    import ctrc_pkg::*;
#(
    parameter int unsigned MAX_TARGETS = DEF_MAX_TARGETS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  ts_req_t req,
    output ts_rsp_t rsp
);

    localparam int IDX_W = $clog2(MAX_TARGETS);
    localparam int CNT_W = $clog2(MAX_TARGETS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TARGETS - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_TARGETS);

    logic [15:0] addr_mem [MAX_TARGETS];

    ts_state_t            state_reg, state_next;
    ts_op_t               op_reg, op_next;
    logic [15:0]          key_reg, key_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [15:0]          rd_data_reg;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [MAX_TARGETS-1:0] vld_reg, vld_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic                 full_reg, full_next;

    logic                 issue;
    logic                 entry_vld;
    logic                 hit;
    logic                 free_here;
    logic                 free_any;
    logic [IDX_W-1:0]     free_idx;
    logic                 finish;
    logic                 mem_we;

    assign issue     = (state_reg == TS_SCAN) && (issue_cnt_reg != CNT_END);
    assign entry_vld = vld_reg[chk_idx_reg];
    assign hit       = chk_vld_reg && entry_vld && (rd_data_reg == key_reg);
    assign free_here = chk_vld_reg && !entry_vld;
    assign free_any  = free_found_reg || free_here;
    assign free_idx  = free_found_reg ? free_idx_reg : chk_idx_reg;
    assign finish    = (state_reg == TS_SCAN)
                       && (hit || (chk_vld_reg && (chk_idx_reg == LAST_IDX)));
    assign mem_we    = finish && (op_reg == TS_ADD) && !hit && free_any;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        issue_cnt_next  = issue_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vld_next        = vld_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        full_next       = full_reg;
        unique case (state_reg)
            TS_IDLE: begin
                if (req.start) begin
                    if (req.op == TS_CLEAR) begin
                        vld_next   = '0;
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        full_next  = 1'b0;
                    end else begin
                        state_next      = TS_SCAN;
                        op_next         = req.op;
                        key_next        = req.addr;
                        issue_cnt_next  = '0;
                        free_found_next = 1'b0;
                    end
                end
            end
            TS_SCAN: begin
                if (issue) begin
                    chk_vld_next   = 1'b1;
                    chk_idx_next   = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (free_here && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
                if (finish) begin
                    state_next   = TS_IDLE;
                    chk_vld_next = 1'b0;
                    done_next    = 1'b1;
                    found_next   = hit;
                    full_next    = (op_reg == TS_ADD) && !hit && !free_any;
                    if (mem_we) begin
                        vld_next[free_idx] = 1'b1;
                    end
                    if ((op_reg == TS_REMOVE) && hit) begin
                        vld_next[chk_idx_reg] = 1'b0;
                    end
                end
            end
            default: state_next = TS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TS_IDLE;
            chk_vld_reg <= 1'b0;
            vld_reg     <= '0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            vld_reg     <= vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        issue_cnt_reg  <= issue_cnt_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        found_reg      <= found_next;
        full_reg       <= full_next;
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= addr_mem[issue_cnt_reg[IDX_W-1:0]];
        end
        if (mem_we) begin
            addr_mem[free_idx] <= key_reg;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.full  = full_reg;

endmodule

### rtl/cpu_trace_rule_checker.sv
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata 80 b, tuser 3 b (event kind)
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata 16 b
// cfg      in   cfg_we                         cfg_addr 2 b, cfg_wdata 16 b
//
// Most events pass through a saved-register memory read, evaluate, and output load.
// Add, remove, and JSR/JMP into ROM from outside ROM with the kernel-entry rule
// on scan the target memory one entry per cycle. aresetn is synchronous; valid
// bits clear at once. A stalled result holds in the output register while the
// next event enters.
`timescale 1ns / 1ps

`include "cpu_trace_rule_checker_assert.svh"

module cpu_trace_rule_checker
    import ctrc_pkg::*;
#(
    parameter int unsigned MAX_TARGETS = DEF_MAX_TARGETS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode, target, insn_pc, reg_a, reg_x, reg_y, stack_ptr, irq_masked, zero fill
    input  logic [79:0] s_axis_tdata,
    // cmd
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // failure, failure_kinds, set_full, zero fill
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [23:0] regs_mem [256];

    top_state_t  state_reg, state_next;
    logic [6:0]  en_reg;
    logic [15:0] rom_low_reg, rom_high_reg, sio_vec_reg;
    logic        nmi_act_reg, nmi_act_next;
    logic [7:0]  nmi_lvl_reg, nmi_lvl_next;
    logic [255:0] regs_vld_reg, regs_vld_next;
    logic [23:0] regs_rd_reg;

    cmd_t        cmd_reg;
    logic [7:0]  op_reg;
    logic [15:0] tgt_reg, pc_reg;
    logic [7:0]  a_reg, x_reg, y_reg, sp_reg;
    logic        irqm_reg;

    logic [6:0]  res_kinds_reg, res_kinds_next;
    logic        res_full_reg, res_full_next;

    logic        m_valid_reg;
    logic [6:0]  m_kinds_reg;
    logic        m_full_reg;

    logic        accept;
    logic        emit_load;
    logic        regs_we;
    logic        tgt_in_rom, pc_in_rom;
    logic        sio_hit;
    logic        slot_vld, regs_mismatch;
    logic [7:0]  nmi_gap;
    logic [6:0]  cfg_off;
    ts_req_t     ts_req;
    ts_rsp_t     ts_rsp;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit_load     = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);

    assign tgt_in_rom    = (tgt_reg >= rom_low_reg) && (tgt_reg <= rom_high_reg);
    assign pc_in_rom     = (pc_reg >= rom_low_reg) && (pc_reg <= rom_high_reg);
    assign sio_hit       = en_reg[EN_SIO] && (tgt_reg == sio_vec_reg) && tgt_in_rom
                           && irqm_reg;
    assign slot_vld      = regs_vld_reg[sp_reg];
    assign regs_mismatch = (regs_rd_reg != {a_reg, x_reg, y_reg});
    assign nmi_gap       = sp_reg - nmi_lvl_reg;
    assign cfg_off       = en_reg & ~cfg_wdata[6:0];

    always_comb begin
        state_next     = state_reg;
        nmi_act_next   = nmi_act_reg;
        nmi_lvl_next   = nmi_lvl_reg;
        regs_vld_next  = regs_vld_reg;
        res_kinds_next = res_kinds_reg;
        res_full_next  = res_full_reg;
        regs_we        = 1'b0;
        ts_req.start   = 1'b0;
        ts_req.op      = TS_LOOKUP;
        ts_req.addr    = tgt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_kinds_next = '0;
                res_full_next  = 1'b0;
                state_next     = ST_EMIT;
                unique case (cmd_reg)
                    CMD_INSN: begin
                        if ((op_reg == OP_LDA_ZP) || (op_reg == OP_LDX_ZP)
                            || (op_reg == OP_LDY_ZP)) begin
                            if (en_reg[EN_ZERO] && (tgt_reg == 16'd0)) begin
                                res_kinds_next[FK_ZERO] = 1'b1;
                            end
                        end else if ((op_reg == OP_JSR) || (op_reg == OP_JMP)) begin
                            if (en_reg[EN_KERN]) begin
                                if (tgt_in_rom && !pc_in_rom) begin
                                    ts_req.start = 1'b1;
                                    ts_req.op    = TS_LOOKUP;
                                    state_next   = ST_WAIT;
                                end
                            end else if (sio_hit) begin
                                res_kinds_next[FK_SIO] = 1'b1;
                            end
                        end else if (op_reg == OP_RTI) begin
                            if (en_reg[EN_IRQR] && slot_vld) begin
                                regs_vld_next[sp_reg] = 1'b0;
                            end
                            if (en_reg[EN_IRQR] && slot_vld && regs_mismatch) begin
                                res_kinds_next[FK_REGS] = 1'b1;
                            end else if (en_reg[EN_NMI] && nmi_act_reg
                                         && (nmi_gap < NMI_WINDOW)) begin
                                nmi_act_next = 1'b0;
                            end
                        end else if (op_abs_x(op_reg)) begin
                            if (en_reg[EN_WRAP] && (tgt_reg < {8'd0, x_reg})) begin
                                res_kinds_next[FK_WRAP] = 1'b1;
                            end
                        end else if (op_y_indexed(op_reg)) begin
                            if (en_reg[EN_WRAP] && (tgt_reg < {8'd0, y_reg})) begin
                                res_kinds_next[FK_WRAP] = 1'b1;
                            end
                        end
                    end
                    CMD_IRQ: begin
                        if (en_reg[EN_IRQR]) begin
                            regs_we               = 1'b1;
                            regs_vld_next[sp_reg] = 1'b1;
                        end
                    end
                    CMD_NMI: begin
                        if (en_reg[EN_IRQR]) begin
                            regs_we               = 1'b1;
                            regs_vld_next[sp_reg] = 1'b1;
                        end
                        if (en_reg[EN_NMI]) begin
                            if (nmi_act_reg) begin
                                res_kinds_next[FK_NMI] = 1'b1;
                            end else begin
                                nmi_lvl_next = sp_reg;
                                nmi_act_next = 1'b1;
                            end
                        end
                    end
                    CMD_RESET: begin
                        nmi_act_next  = 1'b0;
                        regs_vld_next = '0;
                    end
                    CMD_ADD: begin
                        ts_req.start = 1'b1;
                        ts_req.op    = TS_ADD;
                        state_next   = ST_WAIT;
                    end
                    CMD_REMOVE: begin
                        ts_req.start = 1'b1;
                        ts_req.op    = TS_REMOVE;
                        state_next   = ST_WAIT;
                    end
                    CMD_CLEAR: begin
                        ts_req.start = 1'b1;
                        ts_req.op    = TS_CLEAR;
                        state_next   = ST_WAIT;
                    end
                    CMD_DMA: begin
                        if (en_reg[EN_DMA]) begin
                            res_kinds_next[FK_DMA] = 1'b1;
                        end
                    end
                    default: state_next = ST_EMIT;
                endcase
            end
            ST_WAIT: begin
                if (ts_rsp.done) begin
                    state_next = ST_EMIT;
                    if (cmd_reg == CMD_ADD) begin
                        res_full_next = ts_rsp.full;
                    end
                    if ((cmd_reg == CMD_INSN) && !ts_rsp.found) begin
                        res_kinds_next[FK_KERN] = 1'b1;
                        res_kinds_next[FK_SIO]  = sio_hit;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we && (cfg_addr == CFG_ENABLES)) begin
            if (cfg_off[EN_NMI]) begin
                nmi_act_next = 1'b0;
            end
            if (cfg_off[EN_IRQR]) begin
                regs_vld_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            en_reg       <= '0;
            rom_low_reg  <= ROM_LOW_RST;
            rom_high_reg <= ROM_HIGH_RST;
            sio_vec_reg  <= SIO_VEC_RST;
            nmi_act_reg  <= 1'b0;
            nmi_lvl_reg  <= '0;
            regs_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nmi_act_reg  <= nmi_act_next;
            nmi_lvl_reg  <= nmi_lvl_next;
            regs_vld_reg <= regs_vld_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_ENABLES:  en_reg       <= cfg_wdata[6:0];
                    CFG_ROM_LOW:  rom_low_reg  <= cfg_wdata;
                    CFG_ROM_HIGH: rom_high_reg <= cfg_wdata;
                    CFG_SIO_VEC:  sio_vec_reg  <= cfg_wdata;
                    default:      en_reg       <= en_reg;
                endcase
            end
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(s_axis_tuser);
            op_reg   <= s_axis_tdata[7:0];
            tgt_reg  <= s_axis_tdata[23:8];
            pc_reg   <= s_axis_tdata[39:24];
            a_reg    <= s_axis_tdata[47:40];
            x_reg    <= s_axis_tdata[55:48];
            y_reg    <= s_axis_tdata[63:56];
            sp_reg   <= s_axis_tdata[71:64];
            irqm_reg <= s_axis_tdata[72];
        end
        res_kinds_reg <= res_kinds_next;
        res_full_reg  <= res_full_next;
        if (emit_load) begin
            m_kinds_reg <= res_kinds_reg;
            m_full_reg  <= res_full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            regs_rd_reg <= regs_mem[s_axis_tdata[71:64]];
        end
        if (regs_we) begin
            regs_mem[sp_reg] <= {a_reg, x_reg, y_reg};
        end
    end

    ctrc_target_set #(
        .MAX_TARGETS(MAX_TARGETS)
    ) u_target_set (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (ts_req),
        .rsp    (ts_rsp)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_full_reg, m_kinds_reg, |m_kinds_reg};

    `CTRC_ASSERT_IMPL(a_nmi_needs_enable, aclk, aresetn,
        nmi_act_reg, en_reg[EN_NMI], "nmi tracking active with rule off")
    `CTRC_ASSERT_IMPL(a_saved_needs_enable, aclk, aresetn,
        !en_reg[EN_IRQR], regs_vld_reg == '0, "saved registers live with rule off")
    `CTRC_ASSERT_IMPL(a_done_in_wait, aclk, aresetn,
        ts_rsp.done, state_reg == ST_WAIT, "target set done outside wait")
    `CTRC_ASSERT_IMPL(a_full_only_add, aclk, aresetn,
        (state_reg == ST_EMIT) && res_full_reg, cmd_reg == CMD_ADD, "set full on a non-add event")
    `CTRC_ASSERT_NEXT(a_emit_shows, aclk, aresetn,
        emit_load, m_axis_tvalid && (state_reg == ST_IDLE), "result load did not present")

endmodule

### tb/tb_cpu_trace_rule_checker.sv
`timescale 1ns / 1ps

module tb_cpu_trace_rule_checker;
    import ctrc_pkg::*;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  op;
        logic [15:0] tgt;
        logic [15:0] pc;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic        im;
    } trace_ev_t;

    typedef struct packed {
        logic       failure;
        logic [6:0] kinds;
        logic       full;
    } verdict_t;

    typedef struct packed {
        logic       active;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
    } reg_frame_t;

    typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE} rx_pattern_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // opcode, target, insn_pc, reg_a, reg_x, reg_y, stack_ptr, irq_masked, zero fill
    logic [79:0] s_axis_tdata = '0;
    // cmd
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // failure, failure_kinds, set_full, zero fill
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    cpu_trace_rule_checker u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    logic [7:0] x_ops [15] = '{8'h1D, 8'h1E, 8'h3D, 8'h3E, 8'h5D, 8'h5E, 8'h7D, 8'h7E,
                               8'h9D, 8'hBC, 8'hBD, 8'hDD, 8'hDE, 8'hFD, 8'hFE};
    logic [7:0] y_ops [17] = '{8'h19, 8'h39, 8'h59, 8'h79, 8'h99, 8'hB9, 8'hBE, 8'hD9,
                               8'hF9, 8'h11, 8'h31, 8'h51, 8'h71, 8'h91, 8'hB1, 8'hD1,
                               8'hF1};
    logic [7:0] zp_ops [3] = '{OP_LDA_ZP, OP_LDX_ZP, OP_LDY_ZP};

    logic [6:0]  cfg_en = '0;
    logic [15:0] cfg_rom_lo = ROM_LOW_RST;
    logic [15:0] cfg_rom_hi = ROM_HIGH_RST;
    logic [15:0] cfg_sio = SIO_VEC_RST;
    reg_frame_t  frames [256];
    logic        nmi_busy = 1'b0;
    logic [7:0]  nmi_base = '0;
    logic        tgt_valid [DEF_MAX_TARGETS];
    logic [15:0] tgt_addr [DEF_MAX_TARGETS];

    trace_ev_t   trace_q [$];
    verdict_t    verdict_q [$];
    logic [15:0] entry_pool [12];

    int          items_queued = 0;
    int          items_taken = 0;
    int          results_checked = 0;
    int          err_count = 0;
    int          hold_request = 0;
    logic        in_taken = 1'b0;

    function automatic logic in_rom(input logic [15:0] addr);
        return addr >= cfg_rom_lo && addr <= cfg_rom_hi;
    endfunction

    function automatic int find_entry(input logic [15:0] addr);
        for (int i = 0; i < DEF_MAX_TARGETS; i++)
            if (tgt_valid[i] && tgt_addr[i] == addr)
                return i;
        return -1;
    endfunction

    function automatic logic uses_x_index(input logic [7:0] op);
        foreach (x_ops[i])
            if (x_ops[i] == op)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic uses_y_index(input logic [7:0] op);
        foreach (y_ops[i])
            if (y_ops[i] == op)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void clear_frames();
        foreach (frames[i])
            frames[i] = '0;
    endfunction

    function automatic void save_frame(input trace_ev_t ev);
        frames[ev.sp] = '{active: 1'b1, a: ev.a, x: ev.x, y: ev.y};
    endfunction

    function automatic void set_register(input cfg_idx_t idx, input logic [15:0] val);
        logic [6:0] off;
        case (idx)
            CFG_ENABLES: begin
                off = cfg_en & ~val[6:0];
                cfg_en = val[6:0];
                if (off[EN_NMI])
                    nmi_busy = 1'b0;
                if (off[EN_IRQR])
                    clear_frames();
            end
            CFG_ROM_LOW: cfg_rom_lo = val;
            CFG_ROM_HIGH: cfg_rom_hi = val;
            default: cfg_sio = val;
        endcase
    endfunction

    function automatic verdict_t judge_event(input trace_ev_t ev);
        verdict_t   v;
        logic [6:0] k;
        logic       done;
        logic [7:0] sp_gap;
        int         slot;
        k = '0;
        done = 1'b0;
        v.full = 1'b0;
        case (ev.cmd)
            CMD_INSN: begin
                if (ev.op == OP_LDA_ZP || ev.op == OP_LDX_ZP || ev.op == OP_LDY_ZP) begin
                    if (cfg_en[EN_ZERO] && ev.tgt == 16'h0)
                        k[FK_ZERO] = 1'b1;
                end else if (ev.op == OP_JSR || ev.op == OP_JMP) begin
                    if (cfg_en[EN_KERN]) begin
                        if (!in_rom(ev.tgt) || in_rom(ev.pc) || find_entry(ev.tgt) >= 0)
                            done = 1'b1;
                        else
                            k[FK_KERN] = 1'b1;
                    end
                    if (!done && cfg_en[EN_SIO] && ev.tgt == cfg_sio && in_rom(ev.tgt) && ev.im)
                        k[FK_SIO] = 1'b1;
                end else if (ev.op == OP_RTI) begin
                    if (cfg_en[EN_IRQR] && frames[ev.sp].active) begin
                        frames[ev.sp].active = 1'b0;
                        if (frames[ev.sp].a != ev.a || frames[ev.sp].x != ev.x
                                || frames[ev.sp].y != ev.y) begin
                            k[FK_REGS] = 1'b1;
                            done = 1'b1;
                        end
                    end
                    sp_gap = ev.sp - nmi_base;
                    if (!done && cfg_en[EN_NMI] && nmi_busy && sp_gap < NMI_WINDOW)
                        nmi_busy = 1'b0;
                end else if (uses_x_index(ev.op)) begin
                    if (cfg_en[EN_WRAP] && ev.tgt < {8'h0, ev.x})
                        k[FK_WRAP] = 1'b1;
                end else if (uses_y_index(ev.op)) begin
                    if (cfg_en[EN_WRAP] && ev.tgt < {8'h0, ev.y})
                        k[FK_WRAP] = 1'b1;
                end
            end
            CMD_IRQ: begin
                if (cfg_en[EN_IRQR])
                    save_frame(ev);
            end
            CMD_NMI: begin
                if (cfg_en[EN_IRQR])
                    save_frame(ev);
                if (cfg_en[EN_NMI]) begin
                    if (nmi_busy) begin
                        k[FK_NMI] = 1'b1;
                    end else begin
                        nmi_base = ev.sp;
                        nmi_busy = 1'b1;
                    end
                end
            end
            CMD_RESET: begin
                nmi_busy = 1'b0;
                clear_frames();
            end
            CMD_ADD: begin
                if (find_entry(ev.tgt) < 0) begin
                    v.full = 1'b1;
                    for (int i = 0; i < DEF_MAX_TARGETS; i++) begin
                        if (!tgt_valid[i]) begin
                            tgt_valid[i] = 1'b1;
                            tgt_addr[i] = ev.tgt;
                            v.full = 1'b0;
                            break;
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                slot = find_entry(ev.tgt);
                if (slot >= 0)
                    tgt_valid[slot] = 1'b0;
            end
            CMD_CLEAR: begin
                foreach (tgt_valid[i])
                    tgt_valid[i] = 1'b0;
            end
            default: begin
                if (cfg_en[EN_DMA])
                    k[FK_DMA] = 1'b1;
            end
        endcase
        v.failure = (k != '0);
        v.kinds = k;
        return v;
    endfunction

    function automatic trace_ev_t ev_make(input cmd_t c, input logic [7:0] op,
                                          input logic [15:0] tgt, input logic [15:0] pc,
                                          input logic [7:0] a, input logic [7:0] x,
                                          input logic [7:0] y, input logic [7:0] sp,
                                          input logic im);
        return '{cmd: c, op: op, tgt: tgt, pc: pc, a: a, x: x, y: y, sp: sp, im: im};
    endfunction

    function automatic trace_ev_t random_ev();
        return ev_make(cmd_t'($urandom_range(0, 7)), 8'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 1'($urandom));
    endfunction

    function automatic trace_ev_t set_cmd(input cmd_t c, input logic [15:0] addr);
        trace_ev_t ev;
        ev = random_ev();
        ev.cmd = c;
        ev.tgt = addr;
        return ev;
    endfunction

    function automatic logic [7:0] pick_sp();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'hF0, 8'hFF));
    endfunction

    function automatic logic [15:0] rom_addr();
        if (cfg_rom_lo <= cfg_rom_hi)
            return 16'($urandom_range(cfg_rom_hi, cfg_rom_lo));
        return 16'($urandom);
    endfunction

    function automatic trace_ev_t memory_ev();
        trace_ev_t ev;
        ev = random_ev();
        ev.cmd = CMD_INSN;
        case ($urandom_range(0, 3))
            0: begin
                ev.op = zp_ops[$urandom_range(0, 2)];
                ev.tgt = ($urandom_range(0, 1) != 0) ? 16'h0 : 16'($urandom_range(0, 3));
            end
            1: begin
                ev.op = x_ops[$urandom_range(0, 14)];
                ev.tgt = 16'($urandom_range(0, 300));
            end
            2: begin
                ev.op = y_ops[$urandom_range(0, 16)];
                ev.tgt = 16'($urandom_range(0, 300));
            end
            default: ev.tgt = 16'($urandom_range(0, 3));
        endcase
        return ev;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (err_count < 200)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic queue_event(input trace_ev_t ev);
        trace_q.push_back(ev);
        items_queued++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        set_register(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || results_checked < items_queued)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic push_sequence();
        trace_ev_t  ev;
        trace_ev_t  entry;
        logic [7:0] sp;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            queue_event(random_ev());
        end else if (pick < 37) begin
            sp = pick_sp();
            entry = random_ev();
            entry.cmd = ($urandom_range(0, 1) != 0) ? CMD_NMI : CMD_IRQ;
            entry.sp = sp;
            queue_event(entry);
            repeat ($urandom_range(0, 3)) queue_event(memory_ev());
            if ($urandom_range(0, 4) == 0) begin
                ev = random_ev();
                ev.cmd = CMD_NMI;
                ev.sp = sp - 8'd3;
                queue_event(ev);
            end
            ev = entry;
            ev.cmd = CMD_INSN;
            ev.op = OP_RTI;
            ev.tgt = 16'($urandom);
            ev.pc = 16'($urandom);
            ev.im = 1'($urandom);
            if ($urandom_range(0, 9) >= 7)
                ev.sp = sp + 8'($urandom_range(0, 12));
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: ev.a = ev.a ^ (8'h1 << $urandom_range(0, 7));
                    1: ev.x = ev.x ^ (8'h1 << $urandom_range(0, 7));
                    default: ev.y = ev.y ^ (8'h1 << $urandom_range(0, 7));
                endcase
            end
            queue_event(ev);
        end else if (pick < 57) begin
            ev = random_ev();
            ev.cmd = CMD_INSN;
            ev.op = ($urandom_range(0, 1) != 0) ? OP_JSR : OP_JMP;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ev.tgt = entry_pool[$urandom_range(0, 11)];
                4, 5: ev.tgt = cfg_sio;
                6, 7, 8: ev.tgt = rom_addr();
                default: ;
            endcase
            if ($urandom_range(0, 4) != 0) begin
                if (cfg_rom_lo != 16'h0)
                    ev.pc = 16'($urandom_range(0, cfg_rom_lo - 1));
                else if (cfg_rom_hi != 16'hFFFF)
                    ev.pc = 16'($urandom_range(cfg_rom_hi + 1, 16'hFFFF));
            end
            queue_event(ev);
        end else if (pick < 70) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                queue_event(set_cmd(CMD_ADD, entry_pool[$urandom_range(0, 11)]));
            else if (pick < 16)
                queue_event(set_cmd(CMD_REMOVE, entry_pool[$urandom_range(0, 11)]));
            else if (pick < 18)
                queue_event(set_cmd(CMD_ADD, 16'($urandom)));
            else if (pick == 18)
                queue_event(set_cmd(CMD_CLEAR, 16'($urandom)));
            else
                queue_event(set_cmd(CMD_REMOVE, 16'($urandom)));
        end else if (pick < 87) begin
            queue_event(memory_ev());
        end else begin
            case ($urandom_range(0, 2))
                0: queue_event(set_cmd(CMD_RESET, 16'($urandom)));
                1: queue_event(set_cmd(CMD_DMA, 16'($urandom)));
                default: queue_event(random_ev());
            endcase
        end
    endtask

    task automatic fill_target_set();
        logic [15:0] base;
        trace_ev_t   ev;
        base = 16'($urandom_range(16'hC000, 16'hF000));
        queue_event(set_cmd(CMD_CLEAR, base));
        for (int i = 0; i < DEF_MAX_TARGETS + 2; i++)
            queue_event(set_cmd(CMD_ADD, 16'(base + i * 7)));
        for (int i = 0; i < 6; i++) begin
            ev = random_ev();
            ev.cmd = CMD_INSN;
            ev.op = OP_JSR;
            ev.tgt = 16'(base + $urandom_range(0, DEF_MAX_TARGETS + 3) * 7);
            ev.pc = 16'h1000;
            queue_event(ev);
        end
        queue_event(set_cmd(CMD_REMOVE, base));
        queue_event(set_cmd(CMD_ADD, 16'(base + (DEF_MAX_TARGETS + 5) * 7)));
        queue_event(set_cmd(CMD_ADD, 16'(base + 7)));
        queue_event(set_cmd(CMD_ADD, 16'(base + (DEF_MAX_TARGETS + 6) * 7)));
    endtask

    trace_ev_t tx_ev;
    int        tx_burst_left = 1;
    int        tx_gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // hold until the transaction completes
        end else if (tx_gap_left > 0) begin
            tx_gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (trace_q.size() != 0) begin
            tx_ev = trace_q.pop_front();
            s_axis_tuser <= tx_ev.cmd;
            s_axis_tdata <= {7'b0, tx_ev.im, tx_ev.sp, tx_ev.y, tx_ev.x, tx_ev.a,
                             tx_ev.pc, tx_ev.tgt, tx_ev.op};
            s_axis_tvalid <= 1'b1;
            tx_burst_left--;
            if (tx_burst_left <= 0) begin
                tx_gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                tx_burst_left = $urandom_range(1, 40);
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    rx_pattern_t rx_mode = RX_STEADY;
    int          rx_run_left = 0;
    int          rx_hold_left = 0;
    int          hold_seen = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            rx_hold_left = 250;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_run_left == 0) begin
                rx_mode = rx_pattern_t'($urandom_range(0, 2));
                rx_run_left = $urandom_range(10, 150);
            end
            rx_run_left--;
            case (rx_mode)
                RX_STEADY: m_axis_tready <= 1'b1;
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    trace_ev_t mon_ev;
    verdict_t  got_v;
    verdict_t  want_v;

    always @(posedge aclk) begin
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            mon_ev.cmd = cmd_t'(s_axis_tuser);
            {mon_ev.im, mon_ev.sp, mon_ev.y, mon_ev.x, mon_ev.a, mon_ev.pc, mon_ev.tgt,
             mon_ev.op} = s_axis_tdata[72:0];
            verdict_q.push_back(judge_event(mon_ev));
            items_taken++;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_v.failure = m_axis_tdata[0];
            got_v.kinds = m_axis_tdata[7:1];
            got_v.full = m_axis_tdata[8];
            if (verdict_q.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing pending",
                                        results_checked));
            end else begin
                want_v = verdict_q.pop_front();
                if (got_v.failure !== want_v.failure)
                    flag_mismatch($sformatf("result %0d: failure %b, want %b",
                                            results_checked, got_v.failure, want_v.failure));
                if (got_v.kinds !== want_v.kinds)
                    flag_mismatch($sformatf("result %0d: failure_kinds %h, want %h",
                                            results_checked, got_v.kinds, want_v.kinds));
                if (got_v.full !== want_v.full)
                    flag_mismatch($sformatf("result %0d: set_full %b, want %b",
                                            results_checked, got_v.full, want_v.full));
            end
            results_checked++;
        end
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int          phase_start;
        logic [6:0]  en_v;
        int          lo_v;
        int          hi_v;
        int          sio_v;
        clear_frames();
        foreach (tgt_valid[i]) begin
            tgt_valid[i] = 1'b0;
            tgt_addr[i] = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        write_reg(CFG_ENABLES, 16'h007F);
        queue_event(ev_make(CMD_ADD, 8'h00, 16'hE000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
        queue_event(ev_make(CMD_ADD, 8'h00, 16'hE000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
        queue_event(ev_make(CMD_INSN, OP_JSR, 16'hE000, 16'h2000, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, OP_JSR, 16'hE100, 16'h2000, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, OP_JMP, 16'hE100, 16'hC100, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, OP_JSR, 16'h1000, 16'h2000, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, OP_JSR, SIO_VEC_RST, 16'h0000, 8'h00, 8'h00, 8'h00,
                            8'hFF, 1));
        queue_event(ev_make(CMD_REMOVE, 8'h00, 16'hE000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
        queue_event(ev_make(CMD_REMOVE, 8'h00, 16'hE000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
        queue_event(ev_make(CMD_INSN, OP_JMP, 16'hE000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, OP_LDA_ZP, 16'h0000, 16'h0600, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, OP_LDX_ZP, 16'h0000, 16'h0600, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, 8'h9D, 16'h0005, 16'h0600, 8'h00, 8'h10, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, 8'hB1, 16'h0003, 16'h0600, 8'h00, 8'h00, 8'hFF, 8'hFF, 0));
        queue_event(ev_make(CMD_INSN, 8'h1D, 16'hFFFF, 16'h0600, 8'h00, 8'hFF, 8'h00, 8'hFF, 0));
        queue_event(ev_make(CMD_IRQ, 8'h00, 16'h0000, 16'h0600, 8'h01, 8'h02, 8'h03, 8'hF0, 0));
        queue_event(ev_make(CMD_INSN, OP_RTI, 16'h0000, 16'h0600, 8'h01, 8'h02, 8'h04, 8'hF0, 0));
        queue_event(ev_make(CMD_NMI, 8'h00, 16'h0000, 16'h0600, 8'hAA, 8'hBB, 8'hCC, 8'hFA, 0));
        queue_event(ev_make(CMD_NMI, 8'h00, 16'h0000, 16'h0600, 8'h11, 8'h22, 8'h33, 8'hF7, 0));
        queue_event(ev_make(CMD_INSN, OP_RTI, 16'h0000, 16'h0600, 8'h00, 8'h00, 8'h00, 8'hFD, 0));
        queue_event(ev_make(CMD_INSN, OP_RTI, 16'h0000, 16'h0600, 8'hAA, 8'hBB, 8'hCC, 8'hFA, 0));
        queue_event(ev_make(CMD_DMA, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
        queue_event(ev_make(CMD_RESET, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
        queue_event(ev_make(CMD_CLEAR, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
        queue_event(ev_make(CMD_INSN, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1));
        wait_drained();

        write_reg(CFG_ENABLES, 16'h0010);
        queue_event(ev_make(CMD_INSN, OP_JSR, SIO_VEC_RST, 16'hE000, 8'h00, 8'h00, 8'h00,
                            8'hFF, 1));
        queue_event(ev_make(CMD_INSN, OP_JMP, SIO_VEC_RST, 16'h1000, 8'h00, 8'h00, 8'h00,
                            8'hFF, 0));
        queue_event(ev_make(CMD_INSN, OP_JSR, 16'hE45A, 16'h1000, 8'h00, 8'h00, 8'h00, 8'hFF, 1));
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            en_v = 7'h7F;
            lo_v = ROM_LOW_RST;
            hi_v = ROM_HIGH_RST;
            sio_v = SIO_VEC_RST;
            case (phase)
                0, 5, 7: ;
                1: en_v = 7'h00;
                2: begin
                    lo_v = 16'h0000;
                    hi_v = 16'hFFFF;
                    sio_v = 16'h0000;
                end
                3: begin
                    lo_v = 16'hFFFF;
                    hi_v = 16'h0000;
                    sio_v = 16'hFFFF;
                end
                4: begin
                    lo_v = SIO_VEC_RST;
                    hi_v = SIO_VEC_RST;
                end
                default: begin
                    en_v = 7'($urandom_range(0, 127));
                    lo_v = $urandom_range(0, 16'hF000);
                    hi_v = lo_v + $urandom_range(16'h100, 16'h3FFF);
                    if (hi_v > 16'hFFFF)
                        hi_v = 16'hFFFF;
                    sio_v = ($urandom_range(0, 1) != 0) ? $urandom_range(hi_v, lo_v)
                                                        : $urandom_range(0, 16'hFFFF);
                end
            endcase
            write_reg(CFG_ENABLES, {9'h0, en_v});
            write_reg(CFG_ROM_LOW, 16'(lo_v));
            write_reg(CFG_ROM_HIGH, 16'(hi_v));
            write_reg(CFG_SIO_VEC, 16'(sio_v));
            foreach (entry_pool[i])
                entry_pool[i] = rom_addr();
            entry_pool[0] = cfg_sio;
            if (phase == 5)
                hold_request++;
            if (phase == 7)
                fill_target_set();
            phase_start = items_queued;
            while (items_queued - phase_start < 100)
                push_sequence();
            wait_drained();
        end

        repeat (80) @(negedge aclk);
        if (verdict_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
